/* rtl/core/hent_pkg.sv */
// Shared constants and types for the histogram entropy rate estimator.
package hent_pkg;

  // Bin count width taken from the input (upper input bits are masked off).
  localparam int unsigned COUNT_BITS    = 24;
  // Fraction bits of the fixed-point log2.
  localparam int unsigned LOG_FRAC_BITS = 16;

  localparam int unsigned BIN_W   = 24;
  localparam int unsigned TOTAL_W = 40;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned RATE_W  = 56;

  // Mantissa is unsigned Q1.30.
  localparam int unsigned MANT_FRAC = 30;
  localparam int unsigned MANT_W    = MANT_FRAC + 1;

  localparam int unsigned EXP_W      = $clog2(TOTAL_W);
  localparam int unsigned PROD_W     = TOTAL_W + EXP_W + LOG_FRAC_BITS;
  localparam int unsigned FRAC_CNT_W = $clog2(LOG_FRAC_BITS + 1);

  localparam logic [TOTAL_W-1:0] COUNT_MASK = {TOTAL_W{1'b1}} >> (TOTAL_W - COUNT_BITS);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};
  localparam logic [RATE_W-1:0]  RATE_MAX   = {RATE_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};

  // Normalizer result handed to the log/multiply unit.
  typedef struct packed {
    logic                done;
    logic [EXP_W-1:0]    exp;
    logic [MANT_W-1:0]   mant;
    logic [TOTAL_W-1:0]  value;
  } norm_res_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOG_N = 6'b000010,
    S_TEND  = 6'b000100,
    S_LOG_T = 6'b001000,
    S_CLOSE = 6'b010000,
    S_SPARE = 6'b100000
  } state_e;

endpackage

/* rtl/core/hent_norm.sv */
// Multi-cycle leading-one normalizer: finds exponent and Q1.30 mantissa.
module hent_norm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [hent_pkg::TOTAL_W-1:0]    value_i,
  output hent_pkg::norm_res_t             res_o
);

  localparam int unsigned W = hent_pkg::TOTAL_W;

  logic                          busy_q, busy_d;
  logic [W-1:0]                  val_q, val_d;
  logic [W-1:0]                  orig_q, orig_d;
  logic [hent_pkg::EXP_W-1:0]    sh_q, sh_d;
  logic                          found;

  // Leading one reached the top bit: result is ready this cycle.
  assign found = busy_q & val_q[W-1];

  always_comb begin
    busy_d = busy_q;
    val_d  = val_q;
    orig_d = orig_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      val_d  = value_i;
      orig_d = value_i;
      sh_d   = '0;
    end else if (busy_q) begin
      priority if (val_q[W-1 -: 8] == '0) begin
        val_d = val_q << 8;
        sh_d  = sh_q + hent_pkg::EXP_W'(8);
      end else if (val_q[W-1 -: 4] == '0) begin
        val_d = val_q << 4;
        sh_d  = sh_q + hent_pkg::EXP_W'(4);
      end else if (val_q[W-1 -: 2] == '0) begin
        val_d = val_q << 2;
        sh_d  = sh_q + hent_pkg::EXP_W'(2);
      end else if (!val_q[W-1]) begin
        val_d = val_q << 1;
        sh_d  = sh_q + hent_pkg::EXP_W'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    orig_q <= orig_d;
    sh_q   <= sh_d;
  end

  assign res_o.done  = found;
  assign res_o.exp   = hent_pkg::EXP_W'(W - 1) - sh_q;
  assign res_o.mant  = val_q[W-1 -: hent_pkg::MANT_W];
  assign res_o.value = orig_q;

endmodule

/* rtl/core/hent_logmul.sv */
// Log2 by repeated squaring; fraction bits stream serially into a Horner product x*log2(x).
module hent_logmul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hent_pkg::norm_res_t           norm_i,
  output logic [hent_pkg::PROD_W-1:0]   prod_o,
  output logic                          done_o
);

  localparam int unsigned MW = hent_pkg::MANT_W;
  localparam int unsigned PW = hent_pkg::PROD_W;
  localparam int unsigned XW = hent_pkg::TOTAL_W;
  localparam int unsigned CW = hent_pkg::FRAC_CNT_W;

  logic              run_q, run_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [MW-1:0]     m_q, m_d;
  logic              bit_q, bit_d;
  logic              bit_vld_q, bit_vld_d;
  logic              bit_last_q, bit_last_d;
  logic              done_q, done_d;
  logic [XW-1:0]     x_q, x_d;
  logic [PW-1:0]     acc_q, acc_d;

  logic [2*MW-1:0]               msq;
  logic [MW:0]                   sq;
  logic [XW+hent_pkg::EXP_W-1:0] xe;

  assign msq = (2*MW)'(m_q) * (2*MW)'(m_q);
  // Drop the Q1.30 fraction scaling after the square.
  assign sq  = msq[hent_pkg::MANT_FRAC +: MW+1];
  assign xe  = (XW+hent_pkg::EXP_W)'(norm_i.value) * (XW+hent_pkg::EXP_W)'(norm_i.exp);

  always_comb begin
    run_d      = run_q;
    cnt_d      = cnt_q;
    m_d        = m_q;
    bit_d      = bit_q;
    bit_vld_d  = 1'b0;
    bit_last_d = 1'b0;
    x_d        = x_q;
    acc_d      = acc_q;
    done_d     = bit_vld_q & bit_last_q;

    if (norm_i.done) begin
      run_d = 1'b1;
      cnt_d = '0;
      m_d   = norm_i.mant;
      x_d   = norm_i.value;
      // Integer part of the log enters the product up front.
      acc_d = PW'(xe);
    end else begin
      if (run_q) begin
        bit_d      = sq[MW];
        bit_vld_d  = 1'b1;
        bit_last_d = (cnt_q == CW'(hent_pkg::LOG_FRAC_BITS - 1));
        m_d        = sq[MW] ? sq[MW:1] : sq[MW-1:0];
        cnt_d      = cnt_q + CW'(1);
        run_d      = (cnt_q != CW'(hent_pkg::LOG_FRAC_BITS - 1));
      end
      if (bit_vld_q) begin
        acc_d = (acc_q << 1) + (bit_q ? PW'(x_q) : PW'(0));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      cnt_q      <= '0;
      bit_vld_q  <= 1'b0;
      bit_last_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      run_q      <= run_d;
      cnt_q      <= cnt_d;
      bit_vld_q  <= bit_vld_d;
      bit_last_q <= bit_last_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    bit_q <= bit_d;
    x_q   <= x_d;
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

/* rtl/core/histogram_entropy_rate.sv */
// Top level: entropy code length estimator over a stream of histogram bins.
//
// Feed one histogram bin count per transfer (start high while busy is low).
// Each nonzero bin is folded into the table total and into the sum of
// n*log2(n); when end_of_table or last_bin is set, the table adds
// T*log2(T) - sum(n*log2(n)) to the running rate. On last_bin the rate
// (16 fraction bits) and the saturation flag appear on rate_bits_o and
// saturated_o for exactly one cycle, marked by result_valid_o, and all
// accumulators clear. The receiver cannot stall: sample the result on that
// cycle. log2 is computed by a leading-one normalizer that shifts by
// 8/4/2/1 bits per cycle, followed by 16 serial squarings of a Q1.30
// mantissa on one 31x31 multiplier; each fraction bit feeds a shift-add
// product x*log2(x), one bit per cycle. Between the transfer of a nonzero
// bin and the next possible transfer lie 2 to 7 normalizer steps, a
// hand-off, 16 squarings, the pipeline registers and the control states;
// a zero bin passes only through the control states. A table end adds one
// log pass over the 40-bit total (0 to 7 normalizer steps) plus a close
// state.
// There is no clearing pass after reset.
module histogram_entropy_rate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [hent_pkg::BIN_W-1:0]      bin_count_i,
  input  logic                            end_of_table_i,
  input  logic                            last_bin_i,
  output logic                            result_valid_o,
  output logic [hent_pkg::RATE_W-1:0]     rate_bits_o,
  output logic                            saturated_o
);

  localparam int unsigned TW   = hent_pkg::TOTAL_W;
  localparam int unsigned SW   = hent_pkg::SUM_W;
  localparam int unsigned RW   = hent_pkg::RATE_W;
  localparam int unsigned PW   = hent_pkg::PROD_W;
  localparam int unsigned SATW = (PW > SW) ? PW : SW + 1;

  hent_pkg::state_e state_q, state_d;

  logic [TW-1:0]  total_q, total_d;
  logic [SW-1:0]  sum_q, sum_d;
  logic [RW-1:0]  rate_q, rate_d;
  logic           sat_q, sat_d;
  logic [SW-1:0]  diff_q, diff_d;
  logic           end_q, end_d;
  logic           last_q, last_d;
  logic           valid_q, valid_d;
  logic [RW-1:0]  out_rate_q, out_rate_d;
  logic           out_sat_q, out_sat_d;

  logic                 norm_start;
  logic [TW-1:0]        norm_value;
  hent_pkg::norm_res_t  norm_res;
  logic [PW-1:0]        lm_prod;
  logic                 lm_done;

  // Datapath terms
  logic [TW-1:0]    n_in;
  logic [TW:0]      t_sum;
  logic [SATW-1:0]  prod_ext;
  logic             prod_clip;
  logic [SW-1:0]    big;
  logic [SW:0]      s_sum;
  logic [SW:0]      d_sub;
  logic [SW:0]      r_sum;
  logic             r_clip;
  logic [RW-1:0]    rate_new;

  assign n_in  = TW'(bin_count_i) & hent_pkg::COUNT_MASK;
  assign t_sum = (TW+1)'(total_q) + (TW+1)'(n_in);

  // Clip the x*log2(x) product to the sum width.
  assign prod_ext  = SATW'(lm_prod);
  assign prod_clip = |(prod_ext >> SW);
  assign big       = prod_clip ? hent_pkg::SUM_MAX : prod_ext[SW-1:0];

  assign s_sum = (SW+1)'(sum_q) + (SW+1)'(big);
  assign d_sub = (SW+1)'(big) - (SW+1)'(sum_q);

  assign r_sum    = (SW+1)'(rate_q) + (SW+1)'(diff_q);
  assign r_clip   = |(r_sum >> RW);
  assign rate_new = r_clip ? hent_pkg::RATE_MAX : r_sum[RW-1:0];

  hent_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .value_i (norm_value),
    .res_o   (norm_res)
  );

  hent_logmul u_logmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .norm_i (norm_res),
    .prod_o (lm_prod),
    .done_o (lm_done)
  );

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    sum_d      = sum_q;
    rate_d     = rate_q;
    sat_d      = sat_q;
    diff_d     = diff_q;
    end_d      = end_q;
    last_d     = last_q;
    valid_d    = 1'b0;
    out_rate_d = out_rate_q;
    out_sat_d  = out_sat_q;
    norm_start = 1'b0;
    norm_value = n_in;

    unique case (state_q)
      hent_pkg::S_IDLE: begin
        if (start) begin
          // Last bin also closes the current table.
          end_d  = end_of_table_i | last_bin_i;
          last_d = last_bin_i;
          if (n_in != '0) begin
            norm_start = 1'b1;
            if (t_sum[TW]) begin
              total_d = hent_pkg::TOTAL_MAX;
              sat_d   = 1'b1;
            end else begin
              total_d = t_sum[TW-1:0];
            end
            state_d = hent_pkg::S_LOG_N;
          end else begin
            state_d = hent_pkg::S_TEND;
          end
        end
      end
      hent_pkg::S_LOG_N: begin
        if (lm_done) begin
          if (s_sum[SW]) begin
            sum_d = hent_pkg::SUM_MAX;
            sat_d = 1'b1;
          end else begin
            sum_d = s_sum[SW-1:0];
          end
          if (prod_clip) begin
            sat_d = 1'b1;
          end
          state_d = hent_pkg::S_TEND;
        end
      end
      hent_pkg::S_TEND: begin
        if (!end_q) begin
          state_d = hent_pkg::S_IDLE;
        end else if (total_q != '0) begin
          norm_start = 1'b1;
          norm_value = total_q;
          state_d    = hent_pkg::S_LOG_T;
        end else begin
          // Empty table adds nothing.
          diff_d  = '0;
          state_d = hent_pkg::S_CLOSE;
        end
      end
      hent_pkg::S_LOG_T: begin
        if (lm_done) begin
          // Negative table rate (only after clipping) adds zero.
          diff_d = d_sub[SW] ? '0 : d_sub[SW-1:0];
          if (prod_clip) begin
            sat_d = 1'b1;
          end
          state_d = hent_pkg::S_CLOSE;
        end
      end
      hent_pkg::S_CLOSE: begin
        total_d = '0;
        sum_d   = '0;
        if (last_q) begin
          out_rate_d = rate_new;
          out_sat_d  = sat_q | r_clip;
          valid_d    = 1'b1;
          rate_d     = '0;
          sat_d      = 1'b0;
        end else begin
          rate_d = rate_new;
          sat_d  = sat_q | r_clip;
        end
        state_d = hent_pkg::S_IDLE;
      end
      default: begin
        state_d = hent_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hent_pkg::S_IDLE;
      total_q <= '0;
      sum_q   <= '0;
      rate_q  <= '0;
      sat_q   <= 1'b0;
      end_q   <= 1'b0;
      last_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      sum_q   <= sum_d;
      rate_q  <= rate_d;
      sat_q   <= sat_d;
      end_q   <= end_d;
      last_q  <= last_d;
      valid_q <= valid_d;
    end
  end

  // Hold the result payload between strobes.
  always_ff @(posedge clk_i) begin
    diff_q     <= diff_d;
    out_rate_q <= out_rate_d;
    out_sat_q  <= out_sat_d;
  end

  assign busy           = (state_q != hent_pkg::S_IDLE);
  assign result_valid_o = valid_q;
  assign rate_bits_o    = out_rate_q;
  assign saturated_o    = out_sat_q;

`ifndef SYNTHESIS
  // A result only follows the close of a final table.
  a_result_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == hent_pkg::S_CLOSE && last_q))
    else $error("result strobe without a closing final table");

  // Accumulators are clear once a result goes out.
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rate_q == '0 && !sat_q && total_q == '0 && sum_q == '0))
    else $error("accumulators not cleared after result");

  // The log units finish only while the sequencer waits for them.
  a_log_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (!norm_res.done && !lm_done))
    else $error("log unit active while idle");

  // An accepted transfer always occupies the sequencer.
  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transfer accepted without leaving idle");
`endif

endmodule

/* tb/sv/histogram_entropy_rate_test.sv */
// Self-checking testbench for the histogram entropy rate estimator.
module histogram_entropy_rate_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Quiet cycles (no transfer in, no result out) before the run is declared hung.
  // The slowest legal gap is one bin log pass plus a table close.
  localparam int unsigned STALL_LIMIT   = 4000;
  // Cycles to keep watching after the last expected rate has arrived.
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned RANDOM_ITEMS  = 440;
  // Equal full-scale bins in one long flat table.
  localparam int unsigned CLIP_RUN_BINS = 40;
  localparam int unsigned DIRECTED_ROWS = 20;

  typedef struct packed {
    logic [hent_pkg::RATE_W-1:0] rate;
    logic                        sat;
  } rate_result_t;

  // One row of directed stimulus; typed rows carry their own expected rate.
  typedef struct packed {
    logic [hent_pkg::BIN_W-1:0]  bin;
    logic                        eot;
    logic                        last;
    logic                        typed;
    logic [hent_pkg::RATE_W-1:0] rate;
    logic                        sat;
  } bin_row_t;

  logic                        clk_i;
  logic                        rst_ni         = 1'b0;
  logic                        start          = 1'b0;
  logic                        busy;
  logic [hent_pkg::BIN_W-1:0]  bin_count_i    = '0;
  logic                        end_of_table_i = 1'b0;
  logic                        last_bin_i     = 1'b0;
  logic                        result_valid_o;
  logic [hent_pkg::RATE_W-1:0] rate_bits_o;
  logic                        saturated_o;

  histogram_entropy_rate i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .bin_count_i,
    .end_of_table_i,
    .last_bin_i,
    .result_valid_o,
    .rate_bits_o,
    .saturated_o
  );

  // Shadow copy of the block's accumulators, advanced once per accepted bin.
  logic [hent_pkg::TOTAL_W-1:0] tbl_total  = '0;
  logic [hent_pkg::SUM_W-1:0]   tbl_nlogn  = '0;
  logic [hent_pkg::RATE_W-1:0]  acc_rate   = '0;
  logic                         clip_seen  = 1'b0;

  rate_result_t rate_due_q[$];
  bin_row_t     directed_bins[DIRECTED_ROWS];

  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned rand_items      = 0;
  int unsigned sender_idle_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fixed-point log2: integer part from the leading one, then the fraction
  // bit by bit from repeated truncating squarings of the Q1.30 mantissa.
  function automatic logic [hent_pkg::SUM_W-1:0] fixed_log2(
      input logic [hent_pkg::SUM_W-1:0] n);
    int unsigned e;
    int unsigned i;
    logic [63:0] m;
    logic [63:0] frac;
    if (n == '0) return '0;
    e = 0;
    while (e < 63 && (n >> (e + 1)) != 0) e++;
    if (e <= hent_pkg::MANT_FRAC) m = n << (hent_pkg::MANT_FRAC - e);
    else m = n >> (e - hent_pkg::MANT_FRAC);
    frac = '0;
    for (i = 0; i < hent_pkg::LOG_FRAC_BITS; i++) begin
      m = (m * m) >> hent_pkg::MANT_FRAC;
      frac = frac << 1;
      if (m >= (64'd1 << (hent_pkg::MANT_FRAC + 1))) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (64'(e) << hent_pkg::LOG_FRAC_BITS) | frac;
  endfunction

  // Clip a 64-bit product at full scale and remember that it clipped.
  function automatic logic [hent_pkg::SUM_W-1:0] clip_mul(input logic [63:0] a,
                                                          input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] != '0) begin
      clip_seen = 1'b1;
      return hent_pkg::SUM_MAX;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] clip_add(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] max);
    if (a > max || b > max - a) begin
      clip_seen = 1'b1;
      return max;
    end
    return a + b;
  endfunction

  // Fold one accepted bin into the shadow state; return 1 when it yields a rate.
  function automatic bit entropy_fold(input logic [hent_pkg::BIN_W-1:0] bin,
                                      input logic eot, input logic last,
                                      output rate_result_t res);
    logic [63:0] n;
    logic [63:0] big;
    logic [63:0] diff;
    res = '0;
    n = 64'(bin) & 64'(hent_pkg::COUNT_MASK);
    // Skip zero bins entirely; their end marks still act below.
    if (n != '0) begin
      tbl_total = hent_pkg::TOTAL_W'(clip_add(64'(tbl_total), n,
                                              64'(hent_pkg::TOTAL_MAX)));
      tbl_nlogn = clip_add(tbl_nlogn, clip_mul(n, fixed_log2(n)), hent_pkg::SUM_MAX);
    end
    // Close the table; last_bin closes it even without end_of_table.
    if (eot || last) begin
      if (tbl_total != '0) begin
        big = clip_mul(64'(tbl_total), fixed_log2(64'(tbl_total)));
        // Drop a negative table rate (possible only after a clip).
        diff = (big > tbl_nlogn) ? big - tbl_nlogn : 64'd0;
        acc_rate = hent_pkg::RATE_W'(clip_add(64'(acc_rate), diff,
                                              64'(hent_pkg::RATE_MAX)));
      end
      tbl_total = '0;
      tbl_nlogn = '0;
    end
    if (last) begin
      res.rate  = acc_rate;
      res.sat   = clip_seen;
      acc_rate  = '0;
      clip_seen = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR at %0t ns: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Present one bin and hold it until the transfer happens. Idle cycles are
  // inserted before the bin at the current sender idle rate.
  task automatic send_bin(input logic [hent_pkg::BIN_W-1:0] bin, input logic eot,
                          input logic last, input bit typed,
                          input rate_result_t typed_res);
    rate_result_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    bin_count_i    <= bin;
    end_of_table_i <= eot;
    last_bin_i     <= last;
    do @(posedge clk_i); while (busy);
    // The transfer happened at this edge: predict now, ahead of any result.
    if (entropy_fold(bin, eot, last, res)) rate_due_q.push_back(typed ? typed_res : res);
  endtask

  // Mix of zero, small, power-of-two, full-scale and fully random counts.
  function automatic logic [hent_pkg::BIN_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return hent_pkg::BIN_W'($urandom_range(15, 1));
      2:       return {hent_pkg::BIN_W{1'b1}};
      3:       return hent_pkg::BIN_W'(1) << $urandom_range(hent_pkg::BIN_W - 1);
      4, 5:    return hent_pkg::BIN_W'($urandom_range(255, 1));
      default: return hent_pkg::BIN_W'($urandom());
    endcase
  endfunction

  // One well-formed stream: a few tables of a few bins, closed by last_bin.
  // Sprinkle stray table ends inside tables and occasionally end the stream
  // on last_bin alone or with an all-zero table.
  task automatic send_stream();
    int unsigned ntab;
    int unsigned nb;
    int unsigned t;
    int unsigned b;
    bit zero_tab;
    bit final_bin;
    logic [hent_pkg::BIN_W-1:0] bin;
    logic eot;
    ntab = $urandom_range(4, 1);
    for (t = 0; t < ntab; t++) begin
      nb = $urandom_range(8, 1);
      zero_tab = ($urandom_range(9) == 0);
      for (b = 0; b < nb; b++) begin
        final_bin = (t == ntab - 1) && (b == nb - 1);
        bin = zero_tab ? '0 : pick_count();
        if (b == nb - 1) eot = final_bin ? 1'($urandom_range(1)) : 1'b1;
        else eot = ($urandom_range(19) == 0);
        send_bin(bin, eot, final_bin, 1'b0, '0);
        rand_items++;
      end
    end
  endtask

  initial begin
    int unsigned k;
    int unsigned phase;
    int unsigned idle_by_phase[3];
    idle_by_phase = '{27, 48, 0};

    // Directed rows: {bin, end_of_table, last_bin, typed, rate, saturated}.
    directed_bins = '{
      // Fresh out of reset, a lone zero bin closes an empty stream: rate 0.
      '{24'd0,        1'b0, 1'b1, 1'b1, 56'd0,             1'b0},
      // A single count of one has log2 zero: rate 0.
      '{24'd1,        1'b0, 1'b1, 1'b1, 56'd0,             1'b0},
      // Two symbols, one each: exactly 2 bits.
      '{24'd1,        1'b0, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'd1,        1'b1, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'd0,        1'b0, 1'b1, 1'b1, 56'd131072,        1'b0},
      // Last bin without table end still closes the table: 4 bits.
      '{24'd2,        1'b0, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'd2,        1'b0, 1'b1, 1'b1, 56'd262144,        1'b0},
      // Single-bin tables at full scale cost nothing.
      '{24'hFFFFFF,   1'b1, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'hFFFFFF,   1'b0, 1'b1, 1'b1, 56'd0,             1'b0},
      // Empty tables add nothing.
      '{24'd0,        1'b1, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'd0,        1'b1, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'd5,        1'b0, 1'b1, 1'b1, 56'd0,             1'b0},
      // Mixed counts, alternating bit patterns; predicted.
      '{24'hFFFFFF,   1'b0, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'd1,        1'b0, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'd123456,   1'b1, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'hAAAAAA,   1'b0, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'h555555,   1'b1, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'd3,        1'b1, 1'b1, 1'b0, 56'd0,             1'b0},
      // Two equal halves of 2^23: one bit per symbol, 2^24 symbols.
      '{24'h800000,   1'b0, 1'b0, 1'b0, 56'd0,             1'b0},
      '{24'h800000,   1'b1, 1'b1, 1'b1, 56'd1099511627776, 1'b0}
    };

    // Hold reset low, then release it at an edge.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = idle_by_phase[0];
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      send_bin(directed_bins[k].bin, directed_bins[k].eot, directed_bins[k].last,
               directed_bins[k].typed, {directed_bins[k].rate, directed_bins[k].sat});
    end

    // Send one long flat table of full-scale bins back to back.
    sender_idle_pct = 0;
    for (k = 0; k < CLIP_RUN_BINS; k++) begin
      send_bin({hent_pkg::BIN_W{1'b1}}, 1'b0, k == CLIP_RUN_BINS - 1, 1'b0, '0);
    end

    // Random streams in three idle regimes.
    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_by_phase[phase];
      while (rand_items < RANDOM_ITEMS * (phase + 1) / 3) send_stream();
    end
    start <= 1'b0;

    // Wait out every pending rate, then watch a little longer for strays.
    while (rate_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Results cannot be held off: sample each one on its strobe cycle and
  // compare it with the oldest pending rate.
  always @(posedge clk_i) begin
    rate_result_t want;
    if (rst_ni && result_valid_o) begin
      if (rate_due_q.size() == 0) begin
        report_mismatch("rate with none pending", 64'(rate_bits_o), 64'd0);
      end else begin
        want = rate_due_q.pop_front();
        if (rate_bits_o !== want.rate) begin
          report_mismatch("rate_bits", 64'(rate_bits_o), 64'(want.rate));
        end
        if (saturated_o !== want.sat) begin
          report_mismatch("saturated", 64'(saturated_o), 64'(want.sat));
        end
      end
    end
  end

  // Watchdog: end the run if neither a transfer nor a result happens for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR at %0t ns: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
